// ----- rtl/core/kfe_pkg.sv -----
package kfe_pkg;

  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_FRAME_W    = 16;
  localparam logic [MAX_FRAME_W-1:0] MAX_FRAME_RST = 16'd1024;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 1'b1;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic        ovf;
    logic        open;
    logic        last;
    logic        add_crc;
    logic [7:0]  hdr;
    logic [7:0]  pay;
    logic [31:0] crc;
  } job_t;

  function automatic logic is_special(input logic [7:0] b);
    return (b == FEND) || (b == FESC);
  endfunction

  function automatic logic [1:0] stuff_len(input logic [7:0] b);
    return is_special(b) ? 2'd2 : 2'd1;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/kfe_front.sv -----
module kfe_front
  import kfe_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_payload_byte,
  input  logic [7:0]            in_header_byte,
  input  logic                  in_frame_first,
  input  logic                  in_frame_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  localparam int SW = ((COUNT_BITS > MAX_FRAME_W) ? COUNT_BITS : MAX_FRAME_W) + 1;
  localparam logic [COUNT_BITS-1:0] CAP = '1;

  logic                   crc_en_r;
  logic [MAX_FRAME_W-1:0] max_r;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic                   drop_r, drop_nxt;

  logic                  accept;
  logic                  skip;
  logic [COUNT_BITS-1:0] count_eff;
  logic                  open;
  logic [31:0]           crc_base;
  logic [31:0]           crc_new;
  logic [31:0]           crc_fin;
  logic                  add_crc;
  logic [3:0]            crc_len;
  logic [3:0]            n;
  logic [SW-1:0]         sum;
  logic                  over;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    skip      = drop_r && !in_frame_first;
    count_eff = in_frame_first ? '0 : count_r;
    open      = (count_eff == '0);
    crc_base  = open ? CRC_ONES : crc_r;
    crc_new   = crc_byte(crc_base, in_payload_byte);
    crc_fin   = crc_new ^ CRC_ONES;
    add_crc   = in_frame_last && crc_en_r;
    crc_len   = {2'd0, stuff_len(crc_fin[7:0])} + {2'd0, stuff_len(crc_fin[15:8])}
              + {2'd0, stuff_len(crc_fin[23:16])} + {2'd0, stuff_len(crc_fin[31:24])};
    n = (open ? 4'd2 : 4'd0) + {2'd0, stuff_len(in_payload_byte)}
      + (in_frame_last ? 4'd1 : 4'd0) + (add_crc ? crc_len : 4'd0);
    sum  = SW'(count_eff) + SW'(n);
    over = (sum > SW'(max_r)) || (sum > SW'(CAP));

    q_push        = accept && !skip;
    q_job.ovf     = over;
    q_job.open    = open;
    q_job.last    = in_frame_last;
    q_job.add_crc = add_crc;
    q_job.hdr     = in_header_byte;
    q_job.pay     = in_payload_byte;
    q_job.crc     = crc_fin;

    count_nxt = count_r;
    crc_nxt   = crc_r;
    drop_nxt  = drop_r;
    if (accept) begin
      if (skip) begin
        drop_nxt = !in_frame_last;
      end else if (over || in_frame_last) begin
        count_nxt = '0;
        crc_nxt   = CRC_ONES;
        drop_nxt  = over && !in_frame_last;
      end else begin
        count_nxt = count_eff + COUNT_BITS'(n);
        crc_nxt   = crc_new;
        drop_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b0;
      max_r    <= MAX_FRAME_RST;
      count_r  <= '0;
      crc_r    <= CRC_ONES;
      drop_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      drop_r  <= drop_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CRC_ENABLE: crc_en_r <= cfg_data[0];
          CFG_MAX_FRAME:  max_r    <= cfg_data[MAX_FRAME_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/kfe_queue.sv -----
module kfe_queue
  import kfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QDEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);

  job_t            mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1)) else $error("queue count slip");

endmodule

// ----- rtl/core/kfe_back.sv -----
module kfe_back
  import kfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_status,
  output logic       out_frame_end,
  output logic       out_run_last
);

  typedef enum logic [2:0] {PH_OPEN, PH_HDR, PH_DATA, PH_CLOSE, PH_OVF} phase_t;

  localparam logic [2:0] DATA_LAST = 3'd4;

  phase_t     phase_r;
  logic       busy_r;
  job_t       job_r;
  logic [2:0] didx_r;
  logic       esc_r;

  logic [7:0] dbyte;
  logic       data_done;
  logic       more_crc;
  logic       done;
  logic       transfer;
  logic       load;

  always_comb begin
    case (didx_r)
      3'd0:    dbyte = job_r.pay;
      3'd1:    dbyte = job_r.crc[7:0];
      3'd2:    dbyte = job_r.crc[15:8];
      3'd3:    dbyte = job_r.crc[23:16];
      default: dbyte = job_r.crc[31:24];
    endcase
    data_done = !is_special(dbyte) || esc_r;
    more_crc  = job_r.add_crc && (didx_r != DATA_LAST);

    out_byte = 8'd0;
    done     = 1'b0;
    case (phase_r)
      PH_OPEN:  out_byte = FEND;
      PH_HDR:   out_byte = job_r.hdr;
      PH_DATA: begin
        if (esc_r) begin
          out_byte = (dbyte == FEND) ? TFEND : TFESC;
        end else begin
          out_byte = is_special(dbyte) ? FESC : dbyte;
        end
        done = data_done && !more_crc && !job_r.last;
      end
      PH_CLOSE: begin
        out_byte = FEND;
        done     = 1'b1;
      end
      PH_OVF:   done = 1'b1;
      default:  done = 1'b1;
    endcase

    out_valid     = busy_r;
    out_status    = (phase_r == PH_OVF);
    out_frame_end = (phase_r == PH_OVF) || (phase_r == PH_CLOSE);
    out_run_last  = done;

    transfer = busy_r && out_ready;
    load     = !busy_r || (transfer && done);
    q_pop    = load && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_OPEN;
      didx_r  <= '0;
      esc_r   <= 1'b0;
    end else if (load) begin
      busy_r <= !q_empty;
      if (!q_empty) begin
        job_r   <= q_job;
        phase_r <= q_job.ovf ? PH_OVF : (q_job.open ? PH_OPEN : PH_DATA);
        didx_r  <= '0;
        esc_r   <= 1'b0;
      end
    end else if (transfer) begin
      case (phase_r)
        PH_OPEN: phase_r <= PH_HDR;
        PH_HDR:  phase_r <= PH_DATA;
        PH_DATA: begin
          if (!data_done) begin
            esc_r <= 1'b1;
          end else begin
            esc_r <= 1'b0;
            if (more_crc) begin
              didx_r <= didx_r + 1'b1;
            end else begin
              phase_r <= PH_CLOSE;
            end
          end
        end
        default: phase_r <= phase_r;
      endcase
    end
  end

  a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_frame_end && out_run_last && (out_byte == 8'd0)))
    else $error("malformed overflow result");
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_run_last)
    else $error("frame end not last of run");
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_run_last) |=> out_valid)
    else $error("run broken before its last byte");

endmodule

// ----- rtl/core/kiss_frame_encoder_crc.sv -----
// Flow: with the sequencer idle, an item that transfers in is written into the job queue and
// then loaded into the sequencer, which offers its first encoded byte.
// Throughput: one output byte per cycle while out_ready is high; an item holds the sequencer
// until its last byte transfers and yields 1 to 13 bytes (none for a dropped item); inputs
// enter one per cycle while the two-entry job queue has room.
// Reset: synchronous active-low rst_n clears the queue, the sequencer, the frame state and the
// configuration (CRC off, frame limit 1024).
module kiss_frame_encoder_crc
  import kfe_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_payload_byte,
  input  logic [7:0]            in_header_byte,
  input  logic                  in_frame_first,
  input  logic                  in_frame_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_status,
  output logic                  out_frame_end,
  output logic                  out_run_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, pop_job;

  kfe_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .in_header_byte  (in_header_byte),
    .in_frame_first  (in_frame_first),
    .in_frame_last   (in_frame_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  kfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  kfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_status    (out_status),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kfe_pkg::*;

  localparam int DRAIN_PAD   = 16;
  localparam int REPORT_MAX  = 10;
  localparam int RUN_LIMIT_NS = 10_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       abort;
    logic       closes;
    logic       run_end;
  } enc_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_payload_byte;
  logic [7:0]            in_header_byte;
  logic                  in_frame_first;
  logic                  in_frame_last;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  out_status;
  logic                  out_frame_end;
  logic                  out_run_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  enc_byte_t expected_bytes[$];

  logic                  cfg_crc_on;
  logic [CFG_DATA_W-1:0] cfg_frame_limit;
  logic [31:0]           crc_state;
  int                    bytes_in_frame;
  logic                  dropping;

  bit in_idle_on;
  bit out_idle_on;
  int stall_request;

  int failures;
  int items_sent;
  int results_checked;
  int frames_closed;
  int overflow_aborts;
  int reg_writes;

  kiss_frame_encoder_crc dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_payload_byte(in_payload_byte),
    .in_header_byte (in_header_byte),
    .in_frame_first (in_frame_first),
    .in_frame_last  (in_frame_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_frame_end  (out_frame_end),
    .out_run_last   (out_run_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  task automatic predict_frame_bytes(input logic [7:0] pay, input logic [7:0] hdr,
                                     input logic first, input logic last);
    logic [7:0]  raw[$];
    logic [7:0]  seq[$];
    logic [31:0] next_crc;
    logic [31:0] sent_crc;
    enc_byte_t   e;
    if (first) begin
      dropping = 1'b0;
      bytes_in_frame = 0;
      crc_state = CRC_ONES;
    end else if (dropping) begin
      if (last) begin
        dropping = 1'b0;
      end
      return;
    end
    if (bytes_in_frame == 0) begin
      crc_state = CRC_ONES;
      seq.push_back(FEND);
      seq.push_back(hdr);
    end
    next_crc = crc_update(crc_state, pay);
    raw.push_back(pay);
    if (last && cfg_crc_on) begin
      sent_crc = next_crc ^ CRC_ONES;
      for (int k = 0; k < 4; k++) begin
        raw.push_back(sent_crc[8*k +: 8]);
      end
    end
    foreach (raw[i]) begin
      if (raw[i] == FEND) begin
        seq.push_back(FESC);
        seq.push_back(TFEND);
      end else if (raw[i] == FESC) begin
        seq.push_back(FESC);
        seq.push_back(TFESC);
      end else begin
        seq.push_back(raw[i]);
      end
    end
    if (last) begin
      seq.push_back(FEND);
    end
    if (bytes_in_frame + seq.size() > int'(cfg_frame_limit)) begin
      e.data = 8'h00;
      e.abort = 1'b1;
      e.closes = 1'b1;
      e.run_end = 1'b1;
      expected_bytes.push_back(e);
      bytes_in_frame = 0;
      crc_state = CRC_ONES;
      dropping = !last;
      return;
    end
    foreach (seq[k]) begin
      e.data = seq[k];
      e.abort = 1'b0;
      e.closes = last && (k == seq.size() - 1);
      e.run_end = (k == seq.size() - 1);
      expected_bytes.push_back(e);
    end
    if (last) begin
      bytes_in_frame = 0;
      crc_state = CRC_ONES;
    end else begin
      bytes_in_frame = bytes_in_frame + seq.size();
      crc_state = next_crc;
    end
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_result();
    enc_byte_t want;
    if (expected_bytes.size() == 0) begin
      note_failure($sformatf("unexpected byte %02h status %0b end %0b last %0b",
                             out_byte, out_status, out_frame_end, out_run_last));
      return;
    end
    want = expected_bytes.pop_front();
    results_checked++;
    if (want.closes && !want.abort) begin
      frames_closed++;
    end
    if (want.abort) begin
      overflow_aborts++;
    end
    if (out_byte !== want.data || out_status !== want.abort ||
        out_frame_end !== want.closes || out_run_last !== want.run_end) begin
      note_failure($sformatf("expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                             want.data, want.abort, want.closes, want.run_end,
                             out_byte, out_status, out_frame_end, out_run_last));
    end
  endtask

  initial begin
    int wait_cycles;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      wait_cycles = out_idle_on ? $urandom_range(0, 13) : 0;
      if (stall_request > 0) begin
        wait_cycles = stall_request;
        stall_request = 0;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result();
    end
  end

  task automatic send_item(input logic [7:0] pay, input logic [7:0] hdr,
                           input logic first, input logic last);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload_byte <= pay;
    in_header_byte <= hdr;
    in_frame_first <= first;
    in_frame_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_frame_bytes(pay, hdr, first, last);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    if (idx == CFG_CRC_ENABLE) begin
      cfg_crc_on = value[0];
    end else begin
      cfg_frame_limit = value;
    end
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return FEND;
      1: return FESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(0, 2));
      2: return 16'($urandom_range(3, 12));
      default: return 16'($urandom_range(13, 60));
    endcase
  endfunction

  task automatic send_frame(input int len);
    logic [7:0] hdr;
    hdr = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      send_item(pick_payload(), (i == 0) ? hdr : 8'($urandom_range(0, 255)),
                i == 0, i == len - 1);
    end
  endtask

  task automatic test_basic_framing();
    send_item(8'h00, 8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 8'hFF, 1'b1, 1'b1);
    send_item(FEND, FEND, 1'b1, 1'b1);
    send_item(FESC, FESC, 1'b1, 1'b1);
    send_item(TFEND, 8'h5A, 1'b1, 1'b0);
    send_item(TFESC, 8'hA5, 1'b0, 1'b0);
    send_item(FEND, 8'h00, 1'b0, 1'b0);
    send_item(FESC, 8'h00, 1'b0, 1'b1);
    send_item(8'h11, 8'h22, 1'b0, 1'b0);
    send_item(8'h33, 8'h44, 1'b1, 1'b0);
    send_item(8'h66, 8'hB6, 1'b1, 1'b1);
  endtask

  task automatic test_crc_append();
    logic [31:0] sent_crc;
    logic [7:0]  odd_byte;
    bit          found;
    wait_for_idle();
    write_reg(CFG_CRC_ENABLE, 16'd1);
    send_item(8'h31, 8'h00, 1'b1, 1'b0);
    send_item(8'h32, 8'h00, 1'b0, 1'b0);
    send_item(8'h33, 8'h00, 1'b0, 1'b1);
    found = 1'b0;
    odd_byte = 8'h00;
    for (int b = 0; b < 256 && !found; b++) begin
      sent_crc = crc_update(CRC_ONES, b[7:0]) ^ CRC_ONES;
      for (int k = 0; k < 4; k++) begin
        if (sent_crc[8*k +: 8] == FEND || sent_crc[8*k +: 8] == FESC) begin
          found = 1'b1;
        end
      end
      if (found) begin
        odd_byte = b[7:0];
      end
    end
    send_item(odd_byte, 8'h7E, 1'b1, 1'b1);
    send_item(FEND, 8'h01, 1'b1, 1'b1);
  endtask

  task automatic test_frame_limit();
    wait_for_idle();
    write_reg(CFG_CRC_ENABLE, 16'd0);
    write_reg(CFG_MAX_FRAME, 16'd0);
    send_item(8'h01, 8'h10, 1'b1, 1'b1);
    wait_for_idle();
    write_reg(CFG_MAX_FRAME, 16'd2);
    send_item(8'h02, 8'h20, 1'b1, 1'b1);
    wait_for_idle();
    write_reg(CFG_MAX_FRAME, 16'd3);
    send_item(8'h03, 8'h30, 1'b1, 1'b0);
    send_item(8'h04, 8'h31, 1'b0, 1'b0);
    send_item(8'h05, 8'h32, 1'b0, 1'b0);
    send_item(8'h06, 8'h33, 1'b0, 1'b1);
    send_item(8'h07, 8'h34, 1'b0, 1'b0);
    send_item(FEND, 8'h35, 1'b0, 1'b0);
    send_item(8'h08, 8'h36, 1'b1, 1'b0);
    send_item(8'h09, 8'h37, 1'b0, 1'b1);
    wait_for_idle();
    write_reg(CFG_MAX_FRAME, 16'd5);
    send_item(8'h0A, 8'h40, 1'b1, 1'b0);
    send_item(8'h0B, 8'h41, 1'b0, 1'b1);
    send_item(FESC, 8'h42, 1'b1, 1'b1);
    send_item(FEND, 8'h43, 1'b1, 1'b0);
    send_item(8'h0C, 8'h44, 1'b0, 1'b1);
    wait_for_idle();
    write_reg(CFG_MAX_FRAME, 16'hFFFF);
    send_frame(4);
  endtask

  task automatic test_random_frames();
    int budget;
    int len;
    for (int phase = 0; phase < 7; phase++) begin
      wait_for_idle();
      write_reg(CFG_CRC_ENABLE, 16'($urandom_range(0, 1)));
      write_reg(CFG_MAX_FRAME, pick_limit());
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      budget = items_sent + 28;
      while (items_sent < budget) begin
        if ($urandom_range(0, 9) < 8) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
          send_frame(len);
        end else begin
          send_item(pick_payload(), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic test_backpressure();
    wait_for_idle();
    write_reg(CFG_CRC_ENABLE, 16'd1);
    write_reg(CFG_MAX_FRAME, 16'hFFFF);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    stall_request = 300;
    repeat (4) send_frame($urandom_range(4, 8));
    wait_for_idle();
    out_idle_on = 1'b1;
    repeat (2) send_frame(6);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_payload_byte <= 8'h00;
    in_header_byte <= 8'h00;
    in_frame_first <= 1'b0;
    in_frame_last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CRC_ENABLE;
    cfg_data <= '0;
    cfg_crc_on = 1'b0;
    cfg_frame_limit = MAX_FRAME_RST;
    crc_state = CRC_ONES;
    bytes_in_frame = 0;
    dropping = 1'b0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    stall_request = 0;
    failures = 0;
    items_sent = 0;
    results_checked = 0;
    frames_closed = 0;
    overflow_aborts = 0;
    reg_writes = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_framing();
    test_crc_append();
    test_frame_limit();
    test_random_frames();
    test_backpressure();
    wait_for_idle();

    failures += expected_bytes.size();
    $display("Run covered %0d input transfers (framed, stray and dropped) and %0d output bytes.",
             items_sent, results_checked);
    $display("It closed %0d frames and aborted %0d on size overflow across %0d register writes.",
             frames_closed, overflow_aborts, reg_writes);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/kfe_pkg.sv
rtl/core/kfe_front.sv
rtl/core/kfe_queue.sv
rtl/core/kfe_back.sv
rtl/core/kiss_frame_encoder_crc.sv
verif/testbench.sv
